// ----- src/sha256_byte_stream_hasher_assert.svh -----
// Assertion macros for the SHA-256 byte stream hasher.
// Each macro checks one implication on the rising edge of clk and is
// switched off while rst is high.
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define SHA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/sha_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// Shared constants, round table and control types of the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam logic        CMD_ABSORB  = 1'b0;
  localparam logic        CMD_FINISH  = 1'b1;
  localparam logic [7:0]  PAD_MARK    = 8'h80;
  localparam logic [5:0]  FILL_LAST   = 6'd63;
  localparam logic [5:0]  LEN_START   = 6'd56;
  localparam logic [6:0]  SCHED_WORDS = 7'd16;
  localparam logic [6:0]  ROUND_COUNT = 7'd64;
  localparam logic [6:0]  COMP_LAST   = 7'd65;
  localparam logic [2:0]  DIGEST_LAST = 3'd7;

  // Control toward the message schedule.
  typedef struct packed {
    logic        push;    // load one assembled message word
    logic [31:0] word;
    logic        step;    // produce one schedule word
    logic        expand;  // schedule word comes from the recurrence
    logic [5:0]  idx;     // round number of the word being produced
  } sched_ctl_t;

  // Control toward the round unit and hash state.
  typedef struct packed {
    logic init;    // copy hash words into working variables
    logic round;   // run one compression round
    logic accum;   // add working variables into hash words
    logic reinit;  // return hash words to the initial values
  } core_ctl_t;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] r;
    unique case (i)
      3'd0: r = 32'h6A09E667;
      3'd1: r = 32'hBB67AE85;
      3'd2: r = 32'h3C6EF372;
      3'd3: r = 32'hA54FF53A;
      3'd4: r = 32'h510E527F;
      3'd5: r = 32'h9B05688C;
      3'd6: r = 32'h1F83D9AB;
      3'd7: r = 32'h5BE0CD19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] r;
    unique case (t)
      6'd0:  r = 32'h428A2F98;  6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hB5C0FBCF;  6'd3:  r = 32'hE9B5DBA5;
      6'd4:  r = 32'h3956C25B;  6'd5:  r = 32'h59F111F1;
      6'd6:  r = 32'h923F82A4;  6'd7:  r = 32'hAB1C5ED5;
      6'd8:  r = 32'hD807AA98;  6'd9:  r = 32'h12835B01;
      6'd10: r = 32'h243185BE;  6'd11: r = 32'h550C7DC3;
      6'd12: r = 32'h72BE5D74;  6'd13: r = 32'h80DEB1FE;
      6'd14: r = 32'h9BDC06A7;  6'd15: r = 32'hC19BF174;
      6'd16: r = 32'hE49B69C1;  6'd17: r = 32'hEFBE4786;
      6'd18: r = 32'h0FC19DC6;  6'd19: r = 32'h240CA1CC;
      6'd20: r = 32'h2DE92C6F;  6'd21: r = 32'h4A7484AA;
      6'd22: r = 32'h5CB0A9DC;  6'd23: r = 32'h76F988DA;
      6'd24: r = 32'h983E5152;  6'd25: r = 32'hA831C66D;
      6'd26: r = 32'hB00327C8;  6'd27: r = 32'hBF597FC7;
      6'd28: r = 32'hC6E00BF3;  6'd29: r = 32'hD5A79147;
      6'd30: r = 32'h06CA6351;  6'd31: r = 32'h14292967;
      6'd32: r = 32'h27B70A85;  6'd33: r = 32'h2E1B2138;
      6'd34: r = 32'h4D2C6DFC;  6'd35: r = 32'h53380D13;
      6'd36: r = 32'h650A7354;  6'd37: r = 32'h766A0ABB;
      6'd38: r = 32'h81C2C92E;  6'd39: r = 32'h92722C85;
      6'd40: r = 32'hA2BFE8A1;  6'd41: r = 32'hA81A664B;
      6'd42: r = 32'hC24B8B70;  6'd43: r = 32'hC76C51A3;
      6'd44: r = 32'hD192E819;  6'd45: r = 32'hD6990624;
      6'd46: r = 32'hF40E3585;  6'd47: r = 32'h106AA070;
      6'd48: r = 32'h19A4C116;  6'd49: r = 32'h1E376C08;
      6'd50: r = 32'h2748774C;  6'd51: r = 32'h34B0BCB5;
      6'd52: r = 32'h391C0CB3;  6'd53: r = 32'h4ED8AA4A;
      6'd54: r = 32'h5B9CCA4F;  6'd55: r = 32'h682E6FF3;
      6'd56: r = 32'h748F82EE;  6'd57: r = 32'h78A5636F;
      6'd58: r = 32'h84C87814;  6'd59: r = 32'h8CC70208;
      6'd60: r = 32'h90BEFFFA;  6'd61: r = 32'hA4506CEB;
      6'd62: r = 32'hBEF9A3F7;  6'd63: r = 32'hC67178F2;
    endcase
    return r;
  endfunction

endpackage

// ----- src/sha_sched.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_sched
// Sixteen-word message window and schedule; registers W[t] + K[t] per round.
// ----------------------------------------------------------------------------
module sha_sched (
  input  logic                clk,
  input  sha_pkg::sched_ctl_t ctl,
  output logic [31:0]         wk
);

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

  // win[0] is the oldest word, win[15] the newest.
  logic [31:0] win [16];
  logic [31:0] sched_word;
  logic [31:0] next_word;

  always_comb begin
    sched_word = ssig1(win[14]) + win[9] + ssig0(win[1]) + win[0];
    // In the first sixteen rounds the window simply rotates.
    next_word  = ctl.expand ? sched_word : win[0];
  end

  always_ff @(posedge clk) begin
    if (ctl.push || ctl.step) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= ctl.push ? ctl.word : next_word;
    end
    if (ctl.step) begin
      wk <= next_word + sha_pkg::round_k(ctl.idx);
    end
  end

endmodule

// ----- src/sha_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_core
// Shared compression round unit, working variables and the eight hash words.
// ----------------------------------------------------------------------------
module sha_core (
  input  logic               clk,
  input  logic               rst,
  input  sha_pkg::core_ctl_t ctl,
  input  logic [31:0]        wk,
  input  logic [2:0]         sel,
  output logic [31:0]        hash_word
);

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // v[0] through v[7] are the working variables a through h.
  logic [31:0] v  [8];
  logic [31:0] hv [8];
  logic [31:0] t1;
  logic [31:0] t2;

  always_comb begin
    t1 = v[7] + bsig1(v[4]) + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + wk;
    t2 = bsig0(v[0]) + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= hv[i];
      end
    end else if (ctl.round) begin
      v[0] <= t1 + t2;
      v[1] <= v[0];
      v[2] <= v[1];
      v[3] <= v[2];
      v[4] <= v[3] + t1;
      v[5] <= v[4];
      v[6] <= v[5];
      v[7] <= v[6];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.reinit) begin
      for (int i = 0; i < 8; i++) begin
        hv[i] <= sha_pkg::init_hash(3'(i));
      end
    end else if (ctl.accum) begin
      for (int i = 0; i < 8; i++) begin
        hv[i] <= hv[i] + v[i];
      end
    end
  end

  assign hash_word = hv[sel];

endmodule

// ----- src/sha256_byte_stream_hasher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 of a byte stream: absorb bytes, then finish to read the digest.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): each beat carries cmd and data_byte.
// An absorb beat (cmd 0) adds one message byte; a finish beat (cmd 1) pads
// the message, runs the last compression(s) and starts the digest.
// Output channel (out_valid/out_ready): a finish yields eight beats, digest
// word 0 (most significant) first, with word_index 0 to 7 and last_word set
// on the eighth beat.
// Flow: an absorb beat keeps in_ready high unless it completes a block. Every
// 64th byte starts a block compression by the single round unit doing one
// round per cycle, after a step that loads the state and before one that adds
// it into the hash. A finish writes padding bytes up to the block end (at most
// 64 bytes, 72 when the padding spills into a second block), runs each
// compression, then gives the eight output beats. No byte is taken while a
// block compresses.
// in_ready is high only when the block is idle. A stalled receiver simply
// holds the digest beats; nothing is lost. Synchronous reset returns the
// hash to the initial values and the byte count to zero.
// ----------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_assert.svh"

module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_OUT
  } state_t;

  state_t      state;
  logic [5:0]  fill;        // byte position inside the current block
  logic [23:0] partial;     // bytes of the word being assembled
  logic [63:0] byte_count;
  logic [6:0]  cnt;         // compression cycle
  logic        fin;         // a finish is in progress
  logic        spill;       // padding needs one more block before the length
  logic [2:0]  widx;

  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [63:0] bit_len;
  logic [7:0]  len_byte;
  logic [31:0] wk;

  sha_pkg::sched_ctl_t sctl;
  sha_pkg::core_ctl_t  cctl;

  assign in_ready    = (state == ST_IDLE);
  assign out_valid   = (state == ST_OUT);
  assign word_index  = widx;
  assign last_word   = (widx == sha_pkg::DIGEST_LAST);

  // The length field sits in bytes 56 to 63 of the final block, big-endian.
  assign bit_len  = {byte_count[60:0], 3'b000};
  assign len_byte = 8'(bit_len >> {~fill[2:0], 3'b000});

  // Byte entry: absorbed bytes come from the port, padding bytes are made
  // here, and both go through the same word assembler.
  always_comb begin
    wr_en   = 1'b0;
    wr_byte = 8'h00;
    unique case (state)
      ST_IDLE: begin
        wr_en   = in_valid;
        wr_byte = (cmd == sha_pkg::CMD_FINISH) ? sha_pkg::PAD_MARK : data_byte;
      end
      ST_PAD: begin
        wr_en   = 1'b1;
        wr_byte = (fill >= sha_pkg::LEN_START && !spill) ? len_byte : 8'h00;
      end
      ST_COMP: begin
      end
      ST_OUT: begin
      end
    endcase
  end

  always_comb begin
    sctl.push   = wr_en && (fill[1:0] == 2'b11);
    sctl.word   = {partial, wr_byte};
    sctl.step   = (state == ST_COMP) && (cnt < sha_pkg::ROUND_COUNT);
    sctl.expand = (cnt >= sha_pkg::SCHED_WORDS);
    sctl.idx    = cnt[5:0];

    cctl.init   = (state == ST_COMP) && (cnt == '0);
    cctl.round  = (state == ST_COMP) && (cnt != '0) && (cnt <= sha_pkg::ROUND_COUNT);
    cctl.accum  = (state == ST_COMP) && (cnt == sha_pkg::COMP_LAST);
    cctl.reinit = (state == ST_OUT) && out_ready && (widx == sha_pkg::DIGEST_LAST);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      partial <= {partial[15:0], wr_byte};
    end
    if (rst) begin
      state      <= ST_IDLE;
      fill       <= '0;
      byte_count <= '0;
      cnt        <= '0;
      fin        <= 1'b0;
      spill      <= 1'b0;
      widx       <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            fill <= fill + 6'd1;
            if (cmd == sha_pkg::CMD_FINISH) begin
              fin   <= 1'b1;
              spill <= (fill >= sha_pkg::LEN_START);
            end else begin
              byte_count <= byte_count + 64'd1;
            end
            if (fill == sha_pkg::FILL_LAST) begin
              state <= ST_COMP;
            end else if (cmd == sha_pkg::CMD_FINISH) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          fill <= fill + 6'd1;
          if (fill == sha_pkg::FILL_LAST) begin
            state <= ST_COMP;
          end
        end
        ST_COMP: begin
          if (cnt == sha_pkg::COMP_LAST) begin
            cnt <= '0;
            if (!fin) begin
              state <= ST_IDLE;
            end else if (spill) begin
              spill <= 1'b0;
              state <= ST_PAD;
            end else begin
              widx  <= '0;
              state <= ST_OUT;
            end
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            widx <= widx + 3'd1;
            if (widx == sha_pkg::DIGEST_LAST) begin
              state      <= ST_IDLE;
              fin        <= 1'b0;
              byte_count <= '0;
            end
          end
        end
      endcase
    end
  end

  sha_sched u_sched (
    .clk (clk),
    .ctl (sctl),
    .wk  (wk)
  );

  sha_core u_core (
    .clk       (clk),
    .rst       (rst),
    .ctl       (cctl),
    .wk        (wk),
    .sel       (widx),
    .hash_word (digest_word)
  );

  `SHA_ASSERT_SAME(a_one_side, out_valid, !in_ready, "input taken while digest is pending")
  `SHA_ASSERT_SAME(a_fill_tracks, state == ST_IDLE, fill == byte_count[5:0], "block fill lost track of byte count")
  `SHA_ASSERT_NEXT(a_digest_done, out_valid && out_ready && last_word, in_ready && byte_count == '0, "hasher not reset after digest")
  `SHA_ASSERT_NEXT(a_absorb_quick, in_valid && in_ready && cmd == sha_pkg::CMD_ABSORB && fill != sha_pkg::FILL_LAST, in_ready, "absorb inside a block stalled")
  `SHA_ASSERT_NEXT(a_out_holds, out_valid && !out_ready, out_valid && $stable(word_index), "digest beat dropped while stalled")

endmodule
